// ===== hdl/ldi_pkg.sv =====
package ldi_pkg;

  localparam int unsigned BUF_DEPTH = 4096;
  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned FILL_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned LEVEL_W = 13;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned COUNT_MAX = 4095;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END = 3'd4;

  localparam logic [1:0] ECHO_NONE = 2'd0;
  localparam logic [1:0] ECHO_PLAIN = 2'd1;
  localparam logic [1:0] ECHO_CARET = 2'd2;
  localparam logic [1:0] ECHO_ERASE = 2'd3;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_QUIT = 2'd2;
  localparam logic [1:0] SIG_SUSP = 2'd3;

  localparam logic [7:0] CHAR_NL = 8'h0a;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CARET_OFS = 8'h40;

  typedef enum logic [2:0] {
    OP_READ,
    OP_SIGNAL,
    OP_STOP,
    OP_START,
    OP_ERASE,
    OP_KILL,
    OP_STORE,
    OP_RAW
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [1:0] sig;
    logic       commit;
    logic [7:0] eof_c;
    logic       erase_echo;
    logic       kill_echo;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         echo_kind;
    logic [7:0]         echo_char;
    logic [COUNT_W-1:0] erase_count;
    logic [1:0]         signal_hit;
    logic               output_stopped;
    logic               line_committed;
    logic               ring_dropped;
    logic               read_valid;
    logic [7:0]         read_data;
    logic [LEVEL_W-1:0] ring_level;
  } res_t;

endpackage

// ===== hdl/line_discipline_input.sv =====
// Terminal input line discipline with a two-entry command queue between the
// classifier and the executor, so up to two items are taken while a result
// waits. An item passes through the command queue and then the registered
// result; a read of a non-empty ring also passes through a read state for the
// ring memory read. A line commit walks the line store one character at a
// time, with a read state and a write state for each character. Configuration
// writes are always taken and must only be issued while the block is idle.
module line_discipline_input (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ldi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ldi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [7:0]                     char_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     echo_kind_o,
  output logic [7:0]                     echo_char_o,
  output logic [11:0]                    erase_count_o,
  output logic [1:0]                     signal_hit_o,
  output logic                           output_stopped_o,
  output logic                           line_committed_o,
  output logic                           ring_dropped_o,
  output logic                           read_valid_o,
  output logic [7:0]                     read_data_o,
  output logic [12:0]                    ring_level_o
);
  import ldi_pkg::*;

  cmd_t front_cmd, queue_cmd;
  res_t res;
  logic q_full, q_valid, q_pop, push;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = !q_full;
  assign push = in_valid_i && !q_full;

  ldi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .func_i      (func_i),
    .char_in_i   (char_in_i),
    .cmd_o       (front_cmd)
  );

  ldi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (queue_cmd)
  );

  ldi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign echo_kind_o = res.echo_kind;
  assign echo_char_o = res.echo_char;
  assign erase_count_o = res.erase_count;
  assign signal_hit_o = res.signal_hit;
  assign output_stopped_o = res.output_stopped;
  assign line_committed_o = res.line_committed;
  assign ring_dropped_o = res.ring_dropped;
  assign read_valid_o = res.read_valid;
  assign read_data_o = res.read_data;
  assign ring_level_o = res.ring_level;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(ring_level_o) <= BUF_DEPTH)
    else $error("ring level above capacity");

  a_read_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_valid_o) |-> (echo_kind_o == ECHO_NONE &&
      signal_hit_o == SIG_NONE && !line_committed_o && !ring_dropped_o))
    else $error("read result mixed with receive result");

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

endmodule

// ===== hdl/ldi_ram.sv =====
module ldi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ldi_front.sv =====
module ldi_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ldi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ldi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          func_i,
  input  logic [7:0]                    char_in_i,
  output ldi_pkg::cmd_t                 cmd_o
);
  import ldi_pkg::*;

  logic [4:0]  mode_q;
  logic [23:0] sig_q;
  logic [15:0] flow_q;
  logic [15:0] edit_q;
  logic [15:0] end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 5'd31;
      sig_q  <= 24'h1a1c03;
      flow_q <= 16'h1113;
      edit_q <= 16'h157f;
      end_q  <= 16'h0004;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q <= cfg_data_i[4:0];
        CFG_SIGNAL: sig_q <= cfg_data_i;
        CFG_FLOW:   flow_q <= cfg_data_i[15:0];
        CFG_EDIT:   edit_q <= cfg_data_i[15:0];
        CFG_END:    end_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic       ctrl_char;

  always_comb begin
    cmd_o = '0;
    cmd_o.ch = char_in_i;
    cmd_o.eof_c = end_q[7:0];
    cmd_o.erase_echo = mode_q[3];
    cmd_o.kill_echo = mode_q[4];
    ctrl_char = (char_in_i < CHAR_SPACE) && (char_in_i != CHAR_NL) &&
                (char_in_i != CHAR_TAB) && (char_in_i != CHAR_CR);
    if (mode_q[2]) begin
      cmd_o.echo_kind = ctrl_char ? ECHO_CARET : ECHO_PLAIN;
      cmd_o.echo_char = ctrl_char ? char_in_i + CARET_OFS : char_in_i;
    end
    cmd_o.commit = (char_in_i == CHAR_NL) || (char_in_i == end_q[15:8]) ||
                   (char_in_i == end_q[7:0]);
    priority if (func_i) begin
      cmd_o.op = OP_READ;
    end else if (mode_q[0] && char_in_i == sig_q[7:0]) begin
      cmd_o.op = OP_SIGNAL;
      cmd_o.sig = SIG_INTR;
    end else if (mode_q[0] && char_in_i == sig_q[15:8]) begin
      cmd_o.op = OP_SIGNAL;
      cmd_o.sig = SIG_QUIT;
    end else if (mode_q[0] && char_in_i == sig_q[23:16]) begin
      cmd_o.op = OP_SIGNAL;
      cmd_o.sig = SIG_SUSP;
    end else if (char_in_i == flow_q[7:0]) begin
      cmd_o.op = OP_STOP;
    end else if (char_in_i == flow_q[15:8]) begin
      cmd_o.op = OP_START;
    end else if (mode_q[1] && char_in_i == edit_q[7:0]) begin
      cmd_o.op = OP_ERASE;
    end else if (mode_q[1] && char_in_i == edit_q[15:8]) begin
      cmd_o.op = OP_KILL;
    end else if (mode_q[1]) begin
      cmd_o.op = OP_STORE;
    end else begin
      cmd_o.op = OP_RAW;
    end
  end

endmodule

// ===== hdl/ldi_queue.sv =====
module ldi_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ldi_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ldi_pkg::cmd_t data_o
);
  import ldi_pkg::*;

  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slot_q[rp_q];

endmodule

// ===== hdl/ldi_back.sv =====
module ldi_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  ldi_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ldi_pkg::res_t res_o
);
  import ldi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WALK_RD = 2'd2;
  localparam logic [1:0] ST_WALK_WR = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     len_q, len_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     wptr_q, wptr_d;
  logic [AW-1:0]     rptr_q, rptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              stop_q, stop_d;
  logic              drop_q, drop_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;
  cmd_t              cmd_q, cmd_d;

  logic          line_we, ring_we;
  logic [7:0]    line_rdata, ring_rdata, ring_wdata;
  logic          go;
  logic          ring_room;

  ldi_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (len_q),
    .wdata_i (cmd_i.ch),
    .raddr_i (idx_q),
    .rdata_o (line_rdata)
  );

  ldi_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wptr_q),
    .wdata_i (ring_wdata),
    .raddr_i (rptr_q),
    .rdata_o (ring_rdata)
  );

  assign go = (state_q == ST_IDLE) && cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = go;
  assign ring_room = fill_q < FILL_W'(BUF_DEPTH);

  always_comb begin
    state_d = state_q;
    len_d = len_q;
    idx_d = idx_q;
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    stop_d = stop_q;
    drop_d = drop_q;
    cmd_d = cmd_q;
    res_d = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    line_we = 1'b0;
    ring_we = 1'b0;
    ring_wdata = cmd_i.ch;

    unique case (state_q)
      ST_IDLE: begin
        if (go) begin
          cmd_d = cmd_i;
          res_d = '0;
          unique case (cmd_i.op)
            OP_READ: begin
              if (fill_q != '0) begin
                state_d = ST_READ;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            OP_SIGNAL: begin
              res_d.signal_hit = cmd_i.sig;
              out_valid_d = 1'b1;
            end
            OP_STOP: begin
              stop_d = 1'b1;
              out_valid_d = 1'b1;
            end
            OP_START: begin
              stop_d = 1'b0;
              out_valid_d = 1'b1;
            end
            OP_ERASE: begin
              if (len_q != '0) begin
                len_d = len_q - 1'b1;
                if (cmd_i.erase_echo) begin
                  res_d.echo_kind = ECHO_ERASE;
                  res_d.erase_count = COUNT_W'(1);
                end
              end
              out_valid_d = 1'b1;
            end
            OP_KILL: begin
              if (len_q != '0 && cmd_i.kill_echo) begin
                res_d.echo_kind = ECHO_ERASE;
                res_d.erase_count = (32'(len_q) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                             : COUNT_W'(len_q);
              end
              len_d = '0;
              out_valid_d = 1'b1;
            end
            OP_STORE: begin
              res_d.echo_kind = cmd_i.echo_kind;
              res_d.echo_char = cmd_i.echo_char;
              if (32'(len_q) < BUF_DEPTH - 1) begin
                line_we = 1'b1;
                len_d = len_q + 1'b1;
              end
              if (cmd_i.commit) begin
                idx_d = '0;
                drop_d = 1'b0;
                state_d = ST_WALK_RD;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            OP_RAW: begin
              res_d.echo_kind = cmd_i.echo_kind;
              res_d.echo_char = cmd_i.echo_char;
              if (ring_room) begin
                ring_we = 1'b1;
                wptr_d = (32'(wptr_q) == BUF_DEPTH - 1) ? '0 : wptr_q + 1'b1;
                fill_d = fill_q + 1'b1;
              end else begin
                res_d.ring_dropped = 1'b1;
              end
              out_valid_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_d.read_valid = 1'b1;
        res_d.read_data = ring_rdata;
        rptr_d = (32'(rptr_q) == BUF_DEPTH - 1) ? '0 : rptr_q + 1'b1;
        fill_d = fill_q - 1'b1;
        out_valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        ring_wdata = line_rdata;
        if (line_rdata != cmd_q.eof_c) begin
          if (ring_room) begin
            ring_we = 1'b1;
            wptr_d = (32'(wptr_q) == BUF_DEPTH - 1) ? '0 : wptr_q + 1'b1;
            fill_d = fill_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
        end
        if (idx_q == len_q - 1'b1) begin
          len_d = '0;
          res_d.line_committed = 1'b1;
          res_d.ring_dropped = drop_d;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = ST_WALK_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    res_d.output_stopped = stop_d;
    res_d.ring_level = LEVEL_W'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q <= '0;
      idx_q <= '0;
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
      stop_q <= 1'b0;
      drop_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
      idx_q <= idx_d;
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
      stop_q <= stop_d;
      drop_q <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    cmd_q <= cmd_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o = res_q;

endmodule
